@@ src/cwr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cwr_pkg
// Shared types and constants of the congestion window and RTO unit.
// ----------------------------------------------------------------------------
package cwr_pkg;

  localparam int SEQ_BITS = 32;
  localparam logic [31:0] SEQ_MASK = 32'((64'd1 << SEQ_BITS) - 64'd1);

  localparam int ALU_W     = 34;
  localparam int RTT_W     = 20;
  localparam int ADDR_W    = 5;
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [31:0] ALL_ONES = '1;

  // register reset values
  localparam logic [15:0] MSS_RST     = 16'd1400;
  localparam logic [31:0] IW_RST      = 32'd4200;
  localparam logic [15:0] GRAN_RST    = 16'd100;
  localparam logic [15:0] MIN_RTO_RST = 16'd1000;
  localparam logic [15:0] HS_RTO_RST  = 16'd3000;

  // state reset values
  localparam logic [31:0] RTO_RST  = 32'd1000;
  localparam logic [31:0] SSTH_RST = ALL_ONES;

  typedef enum logic [1:0] {
    FUNC_ACK,
    FUNC_TIMEOUT,
    FUNC_SAMPLE,
    FUNC_NONE
  } func_e;

  typedef enum logic [2:0] {
    REG_MSS,
    REG_IW,
    REG_GRAN,
    REG_MIN_RTO,
    REG_HS_RTO
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] mss;
    logic [31:0] iw;
    logic [15:0] gran;
    logic [15:0] min_rto;
    logic [15:0] hs_rto;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ACK_DELTA,
    ST_ACK_CMP,
    ST_SS_MIN,
    ST_CA_SQ,
    ST_CA_DIV,
    ST_CA_WAIT,
    ST_GROW,
    ST_TO_RTO,
    ST_TO_CWND,
    ST_TO_FLIGHT,
    ST_TO_FLIGHT1,
    ST_TO_SSTH,
    ST_TO_BOFF,
    ST_SM_START,
    ST_SM_DIFF,
    ST_SM_DIFF2,
    ST_SM_VAR3,
    ST_SM_VAR,
    ST_SM_SRTT7,
    ST_SM_SRTT,
    ST_SM_MAXG,
    ST_SM_RTO,
    ST_SM_FLOOR,
    ST_WB
  } state_e;

endpackage
`default_nettype wire

@@ src/cwr_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cwr_if
// Event and result channels: valid/ready with the payload fields.
// ----------------------------------------------------------------------------
interface cwr_evt_if import cwr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [31:0]      ack_number;
  logic [31:0]      send_next;
  logic [RTT_W-1:0] rtt_sample_ms;
  logic             in_handshake;
  logic             skip_window_update;

  modport source (
    output valid, func, ack_number, send_next, rtt_sample_ms, in_handshake,
           skip_window_update,
    input  ready
  );
  modport sink (
    input  valid, func, ack_number, send_next, rtt_sample_ms, in_handshake,
           skip_window_update,
    output ready
  );
endinterface

interface cwr_res_if import cwr_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] cwnd_bytes;
  logic [31:0] ssthresh_bytes;
  logic [31:0] rto_ms;
  logic [7:0]  backoff_count;

  modport source (
    output valid, cwnd_bytes, ssthresh_bytes, rto_ms, backoff_count,
    input  ready
  );
  modport sink (
    input  valid, cwnd_bytes, ssthresh_bytes, rto_ms, backoff_count,
    output ready
  );
endinterface
`default_nettype wire

@@ src/cwr_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cwr_alu
// Shared add/subtract unit with borrow flag and 32-bit saturated sum.
// ----------------------------------------------------------------------------
module cwr_alu import cwr_pkg::*; (
  input  wire logic [ALU_W-1:0] a_i,
  input  wire logic [ALU_W-1:0] b_i,
  input  wire logic             sub_i,
  output logic      [ALU_W-1:0] res_o,
  output logic                  lt_o,
  output logic      [31:0]      sat_o
);

  always_comb begin
    res_o = sub_i ? (a_i - b_i) : (a_i + b_i);
    // operands never reach 2^33, so the top bit is the borrow
    lt_o  = res_o[ALU_W-1];
    sat_o = (|res_o[ALU_W-1:32]) ? ALL_ONES : res_o[31:0];
  end

endmodule
`default_nettype wire

@@ src/cwr_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cwr_div
// Restoring 32-bit divider, one quotient bit per cycle. A zero divisor
// gives a zero quotient.
// ----------------------------------------------------------------------------
module cwr_div import cwr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic      [31:0] quotient_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [31:0]          rem_q;
  logic [31:0]          quo_q;
  logic [31:0]          dvs_q;
  logic [33:0]          trial;
  logic                 borrow;

  assign trial  = {1'b0, rem_q, quo_q[31]} - {2'b00, dvs_q};
  assign borrow = trial[33];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - DIV_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so 32 bits hold it
      rem_q <= borrow ? {rem_q[30:0], quo_q[31]} : trial[31:0];
      quo_q <= {quo_q[30:0], ~borrow};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = (dvs_q == '0) ? '0 : quo_q;

endmodule
`default_nettype wire

@@ src/cwr_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cwr_regs
// APB configuration registers, one per word address.
// ----------------------------------------------------------------------------
module cwr_regs import cwr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mss     <= MSS_RST;
      cfg_q.iw      <= IW_RST;
      cfg_q.gran    <= GRAN_RST;
      cfg_q.min_rto <= MIN_RTO_RST;
      cfg_q.hs_rto  <= HS_RTO_RST;
    end else if (wr_en) begin
      case (idx)
        REG_MSS:     cfg_q.mss     <= pwdata[15:0];
        REG_IW:      cfg_q.iw      <= pwdata;
        REG_GRAN:    cfg_q.gran    <= pwdata[15:0];
        REG_MIN_RTO: cfg_q.min_rto <= pwdata[15:0];
        REG_HS_RTO:  cfg_q.hs_rto  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MSS:     prdata = {16'b0, cfg_q.mss};
      REG_IW:      prdata = cfg_q.iw;
      REG_GRAN:    prdata = {16'b0, cfg_q.gran};
      REG_MIN_RTO: prdata = {16'b0, cfg_q.min_rto};
      REG_HS_RTO:  prdata = {16'b0, cfg_q.hs_rto};
      default:     prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ src/congestion_window_and_rto_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// congestion_window_and_rto_unit
// Reno congestion window and RFC 6298 retransmission timer for one connection.
// ----------------------------------------------------------------------------
// One event is taken at a time and gives one result: the window, threshold,
// RTO and backoff count after the event. A small sequencer runs each event
// through one shared add/subtract unit, one operation a cycle, plus a 32-step
// restoring divider for congestion-avoidance growth. A skipped ack, or a zero
// advance in congestion avoidance, goes straight to the result; slow start
// adds a clamp step, and congestion avoidance waits for the divider. A
// timeout sets the threshold only on the first backoff. A first RTT sample
// skips the smoothing; a later one takes an extra step when it exceeds the
// smoothed RTT. A new event is taken in the cycle after the result is written
// to the output register, even if that result is not yet collected; a later
// result waits until the held one is taken. Window reset value is 4200 bytes.
// The initial-window register is readable but only the reset value applies.
// ----------------------------------------------------------------------------
module congestion_window_and_rto_unit import cwr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  cwr_evt_if.sink                evt_i,
  cwr_res_if.source              res_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  cfg_t cfg;

  state_e state_q, state_d;

  // architectural state
  logic [31:0]      cwnd_q;
  logic [31:0]      ssth_q;
  logic [RTT_W-1:0] srtt_q;
  logic [RTT_W-1:0] var_q;
  logic [31:0]      rto_q;
  logic [7:0]       boff_q;
  logic             first_q;
  logic             later_q;
  logic [31:0]      last_ack_q;
  logic             out_valid_q;

  // event latch and scratch
  logic [31:0]      ev_ack_q;
  logic [31:0]      ev_snd_q;
  logic [RTT_W-1:0] ev_rtt_q;
  logic             ev_hs_q;
  logic             ev_skip_q;
  logic [31:0]      tmp_q;
  logic [31:0]      aux_q;
  logic [31:0]      out_cwnd_q;
  logic [31:0]      out_ssth_q;
  logic [31:0]      out_rto_q;
  logic [7:0]       out_boff_q;

  logic [ALU_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_sub, alu_lt;
  logic [31:0]      alu_sat;
  logic             div_start, div_done;
  logic [31:0]      div_quo;
  logic [31:0]      mss_sq;
  logic [7:0]       boff_inc;
  logic             evt_fire;
  logic             wb_load;

  cwr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cwr_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res),
    .lt_o  (alu_lt),
    .sat_o (alu_sat)
  );

  cwr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (aux_q),
    .divisor_i  (cwnd_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign mss_sq   = 32'(cfg.mss) * 32'(cfg.mss);
  assign boff_inc = (boff_q == 8'hFF) ? boff_q : boff_q + 8'd1;

  assign evt_i.ready = (state_q == ST_IDLE);
  assign evt_fire    = evt_i.valid && evt_i.ready;
  assign wb_load     = (state_q == ST_WB) && (!out_valid_q || res_o.ready);

  assign res_o.valid          = out_valid_q;
  assign res_o.cwnd_bytes     = out_cwnd_q;
  assign res_o.ssthresh_bytes = out_ssth_q;
  assign res_o.rto_ms         = out_rto_q;
  assign res_o.backoff_count  = out_boff_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (evt_i.valid) begin
          case (func_e'(evt_i.func))
            FUNC_ACK:     state_d = ST_ACK_DELTA;
            FUNC_TIMEOUT: state_d = ST_TO_RTO;
            FUNC_SAMPLE:  state_d = ST_SM_START;
            default:      state_d = ST_WB;
          endcase
        end
      end
      ST_ACK_DELTA: state_d = ST_ACK_CMP;
      ST_ACK_CMP: begin
        if (ev_skip_q) begin
          state_d = ST_WB;
        end else if (alu_lt) begin
          state_d = ST_SS_MIN;
        end else if (tmp_q == '0) begin
          state_d = ST_WB;
        end else begin
          state_d = ST_CA_SQ;
        end
      end
      ST_SS_MIN:  state_d = ST_GROW;
      ST_CA_SQ:   state_d = ST_CA_DIV;
      ST_CA_DIV:  state_d = ST_CA_WAIT;
      ST_CA_WAIT: state_d = div_done ? ST_GROW : ST_CA_WAIT;
      ST_GROW:    state_d = ST_WB;
      ST_TO_RTO:  state_d = ST_TO_CWND;
      ST_TO_CWND: state_d = (boff_q == '0) ? ST_TO_FLIGHT : ST_TO_BOFF;
      ST_TO_FLIGHT:  state_d = ST_TO_FLIGHT1;
      ST_TO_FLIGHT1: state_d = ST_TO_SSTH;
      ST_TO_SSTH:    state_d = ST_TO_BOFF;
      ST_TO_BOFF:    state_d = ST_WB;
      ST_SM_START:   state_d = first_q ? ST_SM_DIFF : ST_SM_MAXG;
      ST_SM_DIFF:    state_d = alu_lt ? ST_SM_DIFF2 : ST_SM_VAR3;
      ST_SM_DIFF2:   state_d = ST_SM_VAR3;
      ST_SM_VAR3:    state_d = ST_SM_VAR;
      ST_SM_VAR:     state_d = ST_SM_SRTT7;
      ST_SM_SRTT7:   state_d = ST_SM_SRTT;
      ST_SM_SRTT:    state_d = ST_SM_MAXG;
      ST_SM_MAXG:    state_d = ST_SM_RTO;
      ST_SM_RTO:     state_d = ST_SM_FLOOR;
      ST_SM_FLOOR:   state_d = ST_WB;
      ST_WB:         state_d = wb_load ? ST_IDLE : ST_WB;
      default:       state_d = ST_IDLE;
    endcase
  end

  // operand selection for the shared unit
  always_comb begin
    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b0;
    div_start = 1'b0;
    case (state_q)
      ST_ACK_DELTA: begin
        alu_a = ALU_W'(ev_ack_q); alu_b = ALU_W'(last_ack_q); alu_sub = 1'b1;
      end
      ST_ACK_CMP: begin
        alu_a = ALU_W'(cwnd_q); alu_b = ALU_W'(ssth_q); alu_sub = 1'b1;
      end
      ST_SS_MIN: begin
        alu_a = ALU_W'(tmp_q); alu_b = ALU_W'(cfg.mss); alu_sub = 1'b1;
      end
      ST_CA_DIV: div_start = 1'b1;
      ST_GROW: begin
        alu_a = ALU_W'(cwnd_q); alu_b = ALU_W'(aux_q);
      end
      ST_TO_RTO: begin
        alu_a = ALU_W'(rto_q); alu_b = ALU_W'(rto_q);
      end
      ST_TO_CWND: begin
        alu_a = ALU_W'(cfg.mss); alu_b = ALU_W'(cfg.mss);
      end
      ST_TO_FLIGHT: begin
        alu_a = ALU_W'(ev_snd_q); alu_b = ALU_W'(last_ack_q); alu_sub = 1'b1;
      end
      ST_TO_FLIGHT1: begin
        alu_a = ALU_W'(tmp_q); alu_b = ALU_W'(1);
      end
      ST_TO_SSTH: begin
        alu_a = ALU_W'(tmp_q[31:1]); alu_b = ALU_W'(aux_q); alu_sub = 1'b1;
      end
      ST_TO_BOFF: begin
        alu_a = ALU_W'(rto_q); alu_b = ALU_W'(cfg.hs_rto); alu_sub = 1'b1;
      end
      ST_SM_DIFF: begin
        alu_a = ALU_W'(srtt_q); alu_b = ALU_W'(ev_rtt_q); alu_sub = 1'b1;
      end
      ST_SM_DIFF2: begin
        alu_a = ALU_W'(ev_rtt_q); alu_b = ALU_W'(srtt_q); alu_sub = 1'b1;
      end
      ST_SM_VAR3: begin
        alu_a = ALU_W'({var_q, 1'b0}); alu_b = ALU_W'(var_q);
      end
      ST_SM_VAR: begin
        alu_a = ALU_W'(aux_q); alu_b = ALU_W'(tmp_q);
      end
      ST_SM_SRTT7: begin
        alu_a = ALU_W'({srtt_q, 3'b000}); alu_b = ALU_W'(srtt_q); alu_sub = 1'b1;
      end
      ST_SM_SRTT: begin
        alu_a = ALU_W'(aux_q); alu_b = ALU_W'(ev_rtt_q);
      end
      ST_SM_MAXG: begin
        alu_a = ALU_W'(cfg.gran); alu_b = ALU_W'({var_q, 2'b00}); alu_sub = 1'b1;
      end
      ST_SM_RTO: begin
        alu_a = later_q ? ALU_W'(srtt_q) : '0; alu_b = ALU_W'(aux_q);
      end
      ST_SM_FLOOR: begin
        alu_a = ALU_W'(rto_q); alu_b = ALU_W'(cfg.min_rto); alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  // control and connection state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cwnd_q      <= IW_RST;
      ssth_q      <= SSTH_RST;
      srtt_q      <= '0;
      var_q       <= '0;
      rto_q       <= RTO_RST;
      boff_q      <= '0;
      first_q     <= 1'b0;
      later_q     <= 1'b0;
      last_ack_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wb_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_ACK_CMP: last_ack_q <= ev_ack_q;
        ST_GROW:    cwnd_q     <= alu_sat;
        ST_TO_RTO:  rto_q      <= alu_sat;
        ST_TO_CWND: cwnd_q     <= alu_res[31:0];
        ST_TO_SSTH: ssth_q     <= alu_lt ? aux_q : {1'b0, tmp_q[31:1]};
        ST_TO_BOFF: begin
          boff_q <= boff_inc;
          // more than two backoffs: next sample starts the estimator over
          if (boff_inc > 8'd2) begin
            first_q <= 1'b0;
          end
          if (ev_hs_q && alu_lt) begin
            rto_q <= 32'(cfg.hs_rto);
          end
        end
        ST_SM_START: begin
          boff_q  <= '0;
          later_q <= first_q;
          if (!first_q) begin
            first_q <= 1'b1;
            srtt_q  <= ev_rtt_q;
            var_q   <= {1'b0, ev_rtt_q[RTT_W-1:1]};
          end
        end
        ST_SM_VAR:   var_q  <= alu_res[RTT_W+1:2];
        ST_SM_SRTT:  srtt_q <= alu_res[RTT_W+2:3];
        ST_SM_RTO:   rto_q  <= alu_sat;
        ST_SM_FLOOR: begin
          if (alu_lt) begin
            rto_q <= 32'(cfg.min_rto);
          end
        end
        default: ;
      endcase
    end
  end

  // event latch, scratch and result payload
  always_ff @(posedge clk_i) begin
    if (evt_fire) begin
      ev_ack_q  <= evt_i.ack_number;
      ev_snd_q  <= evt_i.send_next;
      ev_rtt_q  <= evt_i.rtt_sample_ms;
      ev_hs_q   <= evt_i.in_handshake;
      ev_skip_q <= evt_i.skip_window_update;
    end
    case (state_q)
      ST_ACK_DELTA:  tmp_q <= alu_res[31:0] & SEQ_MASK;
      ST_SS_MIN:     aux_q <= alu_lt ? tmp_q : 32'(cfg.mss);
      ST_CA_SQ:      aux_q <= mss_sq;
      ST_CA_WAIT: begin
        if (div_done) begin
          aux_q <= (div_quo == '0) ? 32'd1 : div_quo;
        end
      end
      ST_TO_CWND:    aux_q <= alu_res[31:0];
      ST_TO_FLIGHT:  tmp_q <= alu_res[31:0] & SEQ_MASK;
      ST_TO_FLIGHT1: tmp_q <= alu_res[31:0] & SEQ_MASK;
      ST_SM_DIFF: begin
        if (!alu_lt) begin
          tmp_q <= alu_res[31:0];
        end
      end
      ST_SM_DIFF2:   tmp_q <= alu_res[31:0];
      ST_SM_VAR3:    aux_q <= alu_res[31:0];
      ST_SM_SRTT7:   aux_q <= alu_res[31:0];
      ST_SM_MAXG:    aux_q <= alu_lt ? 32'({var_q, 2'b00}) : 32'(cfg.gran);
      default: ;
    endcase
    if (wb_load) begin
      out_cwnd_q <= cwnd_q;
      out_ssth_q <= ssth_q;
      out_rto_q  <= rto_q;
      out_boff_q <= boff_q;
    end
  end

  // divider results only arrive while the sequencer waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_CA_WAIT)
    else $error("divider finished outside the wait state");

  // a timeout always leaves a nonzero backoff count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TO_BOFF |=> boff_q != '0)
    else $error("backoff count zero after timeout");

  // threshold changes only on the first backoff of a timeout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ssth_q != $past(ssth_q) |-> $past(state_q) == ST_TO_SSTH)
    else $error("threshold changed outside timeout handling");

  // an accepted event always starts work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_fire |=> state_q != ST_IDLE)
    else $error("event transfer did not start the sequencer");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the congestion window and RTO unit.
// ----------------------------------------------------------------------------
// A short list of directed events runs first. It covers reset values,
// sequence wrap, skipped updates, first and later RTT samples, backoff, and
// zero and full-scale registers. Ten register settings follow, each with
// random events: acks, most of which advance the window, timeouts, samples
// and no-ops. One long run of back-to-back timeouts saturates the RTO and
// the backoff count. Every result is compared against an in-bench model of
// the window and timer state, or a fixed report for some directed rows.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cwr_pkg::*;

  typedef struct packed {
    func_e            func;
    logic [31:0]      ack_number;
    logic [31:0]      send_next;
    logic [RTT_W-1:0] rtt_sample_ms;
    logic             in_handshake;
    logic             skip_window_update;
  } conn_event_t;

  typedef struct packed {
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
    logic [31:0] rto;
    logic [7:0]  backoffs;
  } window_report_t;

  typedef struct packed {
    bit             is_write;
    reg_idx_e       reg_sel;
    logic [31:0]    wdata;
    conn_event_t    ev;
    bit             fixed;
    window_report_t report;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  cwr_evt_if evt ();
  cwr_res_if res ();

  congestion_window_and_rto_unit DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .evt_i   (evt),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // model of the connection state and its registers
  cfg_t        cfg;
  logic [31:0] w_cwnd;
  logic [31:0] w_ssth;
  logic [31:0] w_srtt;
  logic [31:0] w_rttvar;
  logic [31:0] w_rto;
  logic [31:0] w_last_ack;
  logic [7:0]  w_backoffs;
  bit          w_have_sample;

  window_report_t window_reports[$];
  stim_row_t      rows[$];
  int unsigned    mismatches = 0;
  bit             quiet = 1'b0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t ERROR %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
  endtask

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? ALL_ONES : s[31:0];
  endfunction

  function automatic logic [31:0] sat_times(logic [31:0] a, int unsigned k);
    logic [63:0] p;
    p = 64'(a) * 64'(k);
    return (p > 64'(ALL_ONES)) ? ALL_ONES : p[31:0];
  endfunction

  function automatic logic [31:0] max32(logic [31:0] a, logic [31:0] b);
    return (a > b) ? a : b;
  endfunction

  // advance the window/timer state by one event, return what the unit reports
  function automatic window_report_t apply_event(conn_event_t e);
    logic [31:0] delta;
    logic [31:0] mss;
    logic [31:0] two_mss;
    logic [31:0] sq;
    logic [31:0] quot;
    logic [31:0] flight;
    logic [31:0] r;
    logic [31:0] diff;
    mss     = 32'(cfg.mss);
    two_mss = mss << 1;
    r       = 32'(e.rtt_sample_ms);
    case (e.func)
      FUNC_ACK: begin
        delta = (e.ack_number - w_last_ack) & SEQ_MASK;
        if (!e.skip_window_update) begin
          if (w_cwnd < w_ssth) begin
            w_cwnd = sat_sum(w_cwnd, (delta < mss) ? delta : mss);
          end else if (delta != 32'd0) begin
            sq     = mss * mss;
            quot   = (w_cwnd != 32'd0) ? sq / w_cwnd : 32'd0;
            w_cwnd = sat_sum(w_cwnd, (quot == 32'd0) ? 32'd1 : quot);
          end
        end
        w_last_ack = e.ack_number;
      end
      FUNC_TIMEOUT: begin
        w_rto  = sat_times(w_rto, 2);
        w_cwnd = two_mss;
        if (w_backoffs == 8'd0) begin
          flight = (e.send_next - w_last_ack + 32'd1) & SEQ_MASK;
          w_ssth = max32(flight >> 1, two_mss);
        end
        if (w_backoffs != 8'hFF) w_backoffs++;
        // more than two backoffs: next sample starts the estimator over
        if (w_backoffs > 8'd2) w_have_sample = 1'b0;
        if (e.in_handshake && w_rto < 32'(cfg.hs_rto)) w_rto = 32'(cfg.hs_rto);
      end
      FUNC_SAMPLE: begin
        w_backoffs = 8'd0;
        if (!w_have_sample) begin
          w_have_sample = 1'b1;
          w_srtt        = r;
          w_rttvar      = r >> 1;
          w_rto         = max32(32'(cfg.gran), sat_times(w_rttvar, 4));
        end else begin
          diff     = (w_srtt > r) ? w_srtt - r : r - w_srtt;
          w_rttvar = 32'((64'd3 * 64'(w_rttvar) + 64'(diff)) >> 2);
          w_srtt   = 32'((64'd7 * 64'(w_srtt) + 64'(r)) >> 3);
          w_rto    = sat_sum(w_srtt, max32(32'(cfg.gran), sat_times(w_rttvar, 4)));
        end
        if (w_rto < 32'(cfg.min_rto)) w_rto = 32'(cfg.min_rto);
      end
      default: ;
    endcase
    return '{w_cwnd, w_ssth, w_rto, w_backoffs};
  endfunction

  function automatic void add_evt(func_e f, logic [31:0] ack, logic [31:0] sn,
                                  logic [RTT_W-1:0] rtt, logic hs, logic skip,
                                  bit fixed = 1'b0, window_report_t rep = '0);
    stim_row_t row;
    row        = '0;
    row.ev     = '{f, ack, sn, rtt, hs, skip};
    row.fixed  = fixed;
    row.report = rep;
    rows       = {rows, row};
  endfunction

  function automatic void add_write(reg_idx_e idx, logic [31:0] val);
    stim_row_t row;
    row          = '0;
    row.is_write = 1'b1;
    row.reg_sel  = idx;
    row.wdata    = val;
    rows         = {rows, row};
  endfunction

  // mostly well-formed traffic around the current ack point
  function automatic conn_event_t random_event();
    conn_event_t e;
    int unsigned roll;
    int unsigned mss;
    mss                  = 32'(cfg.mss);
    e.func               = func_e'($urandom_range(3));
    e.ack_number         = $urandom;
    e.send_next          = $urandom;
    e.rtt_sample_ms      = RTT_W'($urandom);
    e.in_handshake       = 1'($urandom_range(1));
    e.skip_window_update = ($urandom_range(4) == 0);
    roll = $urandom_range(99);
    if (roll < 4) begin
      e.func = FUNC_NONE;
    end else if (roll < 50) begin
      e.func = FUNC_ACK;
      case ($urandom_range(9))
        0:       e.ack_number = w_last_ack;
        1:       ;  // arbitrary jump
        default: e.ack_number = w_last_ack + $urandom_range(1, 3 * mss + 1);
      endcase
    end else if (roll < 70) begin
      e.func = FUNC_TIMEOUT;
      if ($urandom_range(6) != 0) e.send_next = w_last_ack + $urandom_range(0, 200000);
    end else begin
      e.func = FUNC_SAMPLE;
      case ($urandom_range(19))
        0:       e.rtt_sample_ms = '0;
        1, 2, 3: ;
        default: e.rtt_sample_ms = RTT_W'($urandom_range(1, 4000));
      endcase
    end
    return e;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    logic [31:0] rd;
    logic [31:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    if (pready !== 1'b1) report_mismatch("pready", 32'(pready), 32'd1);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    // initial window only matters at reset, so the model just keeps the value
    case (idx)
      REG_MSS:     cfg.mss     = val[15:0];
      REG_IW:      cfg.iw      = val;
      REG_GRAN:    cfg.gran    = val[15:0];
      REG_MIN_RTO: cfg.min_rto = val[15:0];
      REG_HS_RTO:  cfg.hs_rto  = val[15:0];
      default: ;
    endcase
    want = (idx == REG_IW) ? val : {16'h0, val[15:0]};
    if (rd !== want) report_mismatch("register readback", rd, want);
  endtask

  task automatic send_event(conn_event_t e, bit fixed, window_report_t rep);
    window_report_t pred;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 22) begin
      evt.valid <= 1'b0;
      @(negedge clk);
    end
    evt.valid              <= 1'b1;
    evt.func               <= e.func;
    evt.ack_number         <= e.ack_number;
    evt.send_next          <= e.send_next;
    evt.rtt_sample_ms      <= e.rtt_sample_ms;
    evt.in_handshake       <= e.in_handshake;
    evt.skip_window_update <= e.skip_window_update;
    @(posedge clk);
    while (!evt.ready) @(posedge clk);
    pred = apply_event(e);
    window_reports = {window_reports, (fixed ? rep : pred)};
  endtask

  // unit idle: nothing in flight before touching registers
  task automatic settle();
    @(negedge clk);
    evt.valid <= 1'b0;
    while (window_reports.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(negedge clk) begin
    res.ready <= quiet || ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    window_report_t want;
    if (rst_n && res.valid && res.ready) begin
      if (window_reports.size() == 0) begin
        report_mismatch("unexpected result transfer", res.cwnd_bytes, 32'd0);
      end else begin
        want = window_reports.pop_front();
        if (res.cwnd_bytes !== want.cwnd)
          report_mismatch("cwnd_bytes", res.cwnd_bytes, want.cwnd);
        if (res.ssthresh_bytes !== want.ssthresh)
          report_mismatch("ssthresh_bytes", res.ssthresh_bytes, want.ssthresh);
        if (res.rto_ms !== want.rto)
          report_mismatch("rto_ms", res.rto_ms, want.rto);
        if (res.backoff_count !== want.backoffs)
          report_mismatch("backoff_count", 32'(res.backoff_count), 32'(want.backoffs));
      end
    end
  end

  initial begin
    conn_event_t e;
    cfg_t        c;
    int          wait_cycles;
    rst_n                  = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    evt.valid              = 1'b0;
    evt.func               = FUNC_ACK;
    evt.ack_number         = '0;
    evt.send_next          = '0;
    evt.rtt_sample_ms      = '0;
    evt.in_handshake       = 1'b0;
    evt.skip_window_update = 1'b0;
    res.ready              = 1'b0;

    cfg           = '{MSS_RST, IW_RST, GRAN_RST, MIN_RTO_RST, HS_RTO_RST};
    w_cwnd        = IW_RST;
    w_ssth        = SSTH_RST;
    w_srtt        = '0;
    w_rttvar      = '0;
    w_rto         = RTO_RST;
    w_last_ack    = '0;
    w_backoffs    = '0;
    w_have_sample = 1'b0;

    // reset state, ack wrap, skip, zero advance
    add_evt(FUNC_NONE, ALL_ONES, ALL_ONES, '1, 1'b1, 1'b1,
            1'b1, '{32'd4200, ALL_ONES, 32'd1000, 8'd0});
    add_evt(FUNC_ACK, ALL_ONES, '0, '0, 1'b0, 1'b0,
            1'b1, '{32'd5600, ALL_ONES, 32'd1000, 8'd0});
    add_evt(FUNC_ACK, '0, ALL_ONES, '1, 1'b1, 1'b1,
            1'b1, '{32'd5600, ALL_ONES, 32'd1000, 8'd0});
    add_evt(FUNC_ACK, '0, '0, '0, 1'b0, 1'b0,
            1'b1, '{32'd5600, ALL_ONES, 32'd1000, 8'd0});
    // first sample of zero lands on the RTO floor
    add_evt(FUNC_SAMPLE, '0, '0, '0, 1'b0, 1'b0,
            1'b1, '{32'd5600, ALL_ONES, 32'd1000, 8'd0});
    add_evt(FUNC_SAMPLE, '0, '0, '1, 1'b0, 1'b0);
    // three timeouts: threshold set on the first, estimator cleared on the third
    add_evt(FUNC_TIMEOUT, '0, ALL_ONES, '0, 1'b1, 1'b0);
    add_evt(FUNC_TIMEOUT, '0, '0, '0, 1'b0, 1'b0);
    add_evt(FUNC_TIMEOUT, '0, '0, '0, 1'b1, 1'b0);
    // congestion avoidance, then no advance
    add_evt(FUNC_ACK, 32'd100, '0, '0, 1'b0, 1'b0);
    add_evt(FUNC_ACK, 32'd100, '0, '0, 1'b0, 1'b0);
    add_evt(FUNC_SAMPLE, '0, '0, 20'd50, 1'b0, 1'b0);
    add_evt(FUNC_TIMEOUT, '0, 32'h8000_0063, '0, 1'b1, 1'b0);
    add_evt(FUNC_SAMPLE, '0, '0, 20'd3000, 1'b0, 1'b0);
    // zero MSS: window drops to zero, divide by zero window grows it by one
    add_write(REG_MSS, 32'd0);
    add_evt(FUNC_ACK, 32'h1234, '0, '0, 1'b0, 1'b0);
    add_evt(FUNC_TIMEOUT, '0, 32'h1234, '0, 1'b0, 1'b0);
    add_evt(FUNC_ACK, 32'h1239, '0, '0, 1'b0, 1'b0);
    add_write(REG_MSS, 32'hFFFF);
    add_write(REG_GRAN, 32'hFFFF);
    add_write(REG_MIN_RTO, 32'hFFFF);
    add_write(REG_HS_RTO, 32'hFFFF);
    add_evt(FUNC_SAMPLE, '0, '0, 20'd1, 1'b0, 1'b0);
    add_evt(FUNC_TIMEOUT, '0, 32'h0001_0000, '0, 1'b1, 1'b0);
    add_evt(FUNC_ACK, 32'h0002_0000, '0, '0, 1'b0, 1'b0);
    add_write(REG_GRAN, 32'd0);
    add_write(REG_MIN_RTO, 32'd0);
    add_write(REG_HS_RTO, 32'd0);
    add_evt(FUNC_SAMPLE, '0, '0, '0, 1'b0, 1'b0);
    add_evt(FUNC_TIMEOUT, '0, '0, '0, 1'b1, 1'b0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_write) begin
        settle();
        write_reg(rows[i].reg_sel, rows[i].wdata);
      end else begin
        send_event(rows[i].ev, rows[i].fixed, rows[i].report);
      end
    end

    for (int p = 0; p < 10; p++) begin
      settle();
      case (p)
        0:       c = '{MSS_RST, IW_RST, GRAN_RST, MIN_RTO_RST, HS_RTO_RST};
        1:       c = '{16'hFFFF, ALL_ONES, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        2:       c = '{16'd1, 32'd1, 16'd1, 16'd1, 16'd1};
        3:       c = '0;
        default: begin
          c.mss     = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 9000));
          c.iw      = $urandom;
          c.gran    = 16'($urandom_range(1, 600));
          c.min_rto = 16'($urandom_range(1, 3000));
          c.hs_rto  = 16'($urandom_range(1, 8000));
        end
      endcase
      write_reg(REG_MSS, 32'(c.mss));
      write_reg(REG_IW, c.iw);
      write_reg(REG_GRAN, 32'(c.gran));
      write_reg(REG_MIN_RTO, 32'(c.min_rto));
      write_reg(REG_HS_RTO, 32'(c.hs_rto));
      quiet = (p == 4);
      for (int n = 0; n < 17; n++) begin
        send_event(random_event(), 1'b0, '0);
        if (p == 5 && n == 8) begin
          // timeout storm: RTO and backoff count run into saturation
          repeat (260) begin
            e      = random_event();
            e.func = FUNC_TIMEOUT;
            send_event(e, 1'b0, '0);
          end
        end
      end
    end
    quiet = 1'b0;

    @(negedge clk);
    evt.valid <= 1'b0;
    for (wait_cycles = 0; window_reports.size() != 0 && wait_cycles < 5000; wait_cycles++)
      @(posedge clk);
    if (window_reports.size() != 0)
      report_mismatch("results never delivered", 32'(window_reports.size()), 32'd0);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
